/* hdl/kvd_pkg.sv */
// Package with the shared types, constants and CRC-32C helpers of the record deframer.
`default_nettype none

package kvd_pkg;

	localparam int FP_BYTES = 20;
	localparam int CNT_W = 33;
	localparam logic [CNT_W-1:0] MIN_RECORD = CNT_W'(FP_BYTES + 7);
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_MASK_DELTA = 32'hA282_EAD8;

	localparam logic [2:0] KIND_FP = 3'd0;
	localparam logic [2:0] KIND_COMP = 3'd1;
	localparam logic [2:0] KIND_KEY = 3'd2;
	localparam logic [2:0] KIND_VAL = 3'd3;
	localparam logic [2:0] KIND_STATUS = 3'd4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TRUNC = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_KEY = 3'd3;
	localparam logic [2:0] ST_VAL = 3'd4;
	localparam logic [2:0] ST_CRC_TRUNC = 3'd5;
	localparam logic [2:0] ST_CRC_BAD = 3'd6;

	localparam logic REG_RAW = 1'b0;
	localparam logic REG_LZ4 = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [7:0] in_byte;
	} item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic [2:0]       kind;
		logic [2:0]       status_code;
		logic [CNT_W-1:0] record_length;
		logic             last;
	} res_t;

	typedef struct packed {
		logic [7:0] raw_code;
		logic [7:0] lz4_code;
	} cfg_t;

	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [31:0] crc_masked(input logic [31:0] crc);
		logic [31:0] c;
		c = ~crc;
		return {c[14:0], c[31:15]} + CRC_MASK_DELTA;
	endfunction

endpackage

`default_nettype wire

/* hdl/kvd_if.sv */
// Stream interfaces for the input beats and the result beats of the deframer.
`default_nettype none

interface kvd_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] in_byte;

	modport source(output valid, output mode, output in_byte, input ready);
	modport sink(input valid, input mode, input in_byte, output ready);
endinterface

interface kvd_out_if;
	logic                     valid;
	logic                     ready;
	logic [7:0]               out_byte;
	logic [2:0]               kind;
	logic [2:0]               status_code;
	logic [kvd_pkg::CNT_W-1:0] record_length;
	logic                     last;

	modport source(output valid, output out_byte, output kind, output status_code,
		output record_length, output last, input ready);
	modport sink(input valid, input out_byte, input kind, input status_code,
		input record_length, input last, output ready);
endinterface

`default_nettype wire

/* hdl/kvd_apb_regs.sv */
// APB register file holding the two compression codes.
`default_nettype none

module kvd_apb_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output kvd_pkg::cfg_t    cfg
);

	logic [7:0] raw_code_q;
	logic [7:0] lz4_code_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_code_q <= 8'd0;
			lz4_code_q <= 8'd1;
		end else if (wr_en) begin
			unique case (paddr[2])
				kvd_pkg::REG_RAW: raw_code_q <= pwdata[7:0];
				kvd_pkg::REG_LZ4: lz4_code_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			kvd_pkg::REG_RAW: prdata = {24'd0, raw_code_q};
			kvd_pkg::REG_LZ4: prdata = {24'd0, lz4_code_q};
			default: prdata = 32'd0;
		endcase
	end

	assign cfg.raw_code = raw_code_q;
	assign cfg.lz4_code = lz4_code_q;

endmodule

`default_nettype wire

/* hdl/kvd_parser.sv */
// Record parser: holds the per-record state and computes at most one result per byte.
`default_nettype none

module kvd_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire kvd_pkg::item_t item,
	input  wire kvd_pkg::cfg_t cfg,
	output logic               res_valid,
	output kvd_pkg::res_t      res
);

	localparam logic [3:0] PH_FP = 4'd0;
	localparam logic [3:0] PH_COMP = 4'd1;
	localparam logic [3:0] PH_KLEN = 4'd2;
	localparam logic [3:0] PH_KEY = 4'd3;
	localparam logic [3:0] PH_VLEN = 4'd4;
	localparam logic [3:0] PH_VAL = 4'd5;
	localparam logic [3:0] PH_CRC = 4'd6;
	localparam logic [3:0] PH_KEYBAD = 4'd7;
	localparam logic [3:0] PH_VALBAD = 4'd8;

	localparam int CW = kvd_pkg::CNT_W;

	logic [3:0]    phase_q, phase_d;
	logic [CW-1:0] field_q, field_d;
	logic [CW-1:0] total_q, total_d;
	logic [31:0]   acc_q, acc_d;
	logic [2:0]    shift_q, shift_d;
	logic [31:0]   crc_q, crc_d;
	logic [31:0]   stored_q, stored_d;
	logic          cfault_q, cfault_d;
	logic          disc_q, disc_d;

	logic [7:0]    b;
	logic [CW-1:0] tot1;
	logic [CW-1:0] fc1;
	logic [CW-1:0] fcd;
	logic [31:0]   crc_next;
	logic [31:0]   part;
	logic [31:0]   acc_new;
	logic [31:0]   stored_new;
	logic [2:0]    code;
	logic [3:0]    ph_done;

	assign b = item.in_byte;
	assign crc_next = kvd_pkg::crc32c_byte(crc_q, b);
	assign tot1 = (total_q < kvd_pkg::COUNT_MAX) ? total_q + CW'(1) : total_q;
	assign fc1 = field_q + CW'(1);
	assign fcd = (field_q != '0) ? field_q - CW'(1) : field_q;
	assign acc_new = acc_q | part;

	always_comb begin
		unique case (shift_q)
			3'd0: part = {25'd0, b[6:0]};
			3'd1: part = {18'd0, b[6:0], 7'd0};
			3'd2: part = {11'd0, b[6:0], 14'd0};
			3'd3: part = {4'd0, b[6:0], 21'd0};
			3'd4: part = {b[3:0], 28'd0};
			default: part = 32'd0;
		endcase
	end

	always_comb begin
		unique case (field_q[1:0])
			2'd0: stored_new = stored_q | {24'd0, b};
			2'd1: stored_new = stored_q | {16'd0, b, 8'd0};
			2'd2: stored_new = stored_q | {8'd0, b, 16'd0};
			2'd3: stored_new = stored_q | {b, 24'd0};
			default: stored_new = stored_q;
		endcase
	end

	always_comb begin
		priority if (total_q < kvd_pkg::MIN_RECORD) begin
			code = kvd_pkg::ST_TRUNC;
		end else if (cfault_q) begin
			code = kvd_pkg::ST_COMP;
		end else if (phase_q == PH_KLEN || phase_q == PH_KEY || phase_q == PH_KEYBAD) begin
			code = kvd_pkg::ST_KEY;
		end else if (phase_q == PH_VLEN || phase_q == PH_VAL || phase_q == PH_VALBAD) begin
			code = kvd_pkg::ST_VAL;
		end else if (phase_q == PH_CRC) begin
			code = kvd_pkg::ST_CRC_TRUNC;
		end else begin
			code = kvd_pkg::ST_TRUNC;
		end
	end

	always_comb begin
		if (phase_q == PH_KLEN) begin
			ph_done = (acc_new != 32'd0) ? PH_KEY : PH_VLEN;
		end else begin
			ph_done = (acc_new != 32'd0) ? PH_VAL : PH_CRC;
		end
	end

	always_comb begin
		phase_d = phase_q;
		field_d = field_q;
		total_d = total_q;
		acc_d = acc_q;
		shift_d = shift_q;
		crc_d = crc_q;
		stored_d = stored_q;
		cfault_d = cfault_q;
		disc_d = disc_q;
		res_valid = 1'b0;
		res = '0;

		if (item.mode) begin
			if (disc_q || total_q != '0) begin
				if (!disc_q) begin
					res_valid = 1'b1;
					res.kind = kvd_pkg::KIND_STATUS;
					res.status_code = code;
					res.last = 1'b1;
				end
				disc_d = 1'b0;
				phase_d = PH_FP;
				field_d = '0;
				total_d = '0;
				acc_d = '0;
				shift_d = '0;
				crc_d = kvd_pkg::CRC_INIT;
				stored_d = '0;
				cfault_d = 1'b0;
			end
		end else if (!disc_q) begin
			total_d = tot1;
			if (cfault_q || phase_q == PH_KEYBAD || phase_q == PH_VALBAD) begin
				if (tot1 >= kvd_pkg::MIN_RECORD) begin
					disc_d = 1'b1;
					res_valid = 1'b1;
					res.kind = kvd_pkg::KIND_STATUS;
					res.last = 1'b1;
					res.status_code = cfault_q ? kvd_pkg::ST_COMP :
						((phase_q == PH_KEYBAD) ? kvd_pkg::ST_KEY : kvd_pkg::ST_VAL);
				end
			end else begin
				unique case (phase_q)
					PH_FP: begin
						crc_d = crc_next;
						if (fc1 >= CW'(kvd_pkg::FP_BYTES)) begin
							field_d = '0;
							phase_d = PH_COMP;
						end else begin
							field_d = fc1;
						end
						res_valid = 1'b1;
						res.out_byte = b;
						res.kind = kvd_pkg::KIND_FP;
					end
					PH_COMP: begin
						crc_d = crc_next;
						if (b != cfg.raw_code && b != cfg.lz4_code) begin
							cfault_d = 1'b1;
						end
						phase_d = PH_KLEN;
						acc_d = '0;
						shift_d = '0;
						res_valid = 1'b1;
						res.out_byte = b;
						res.kind = kvd_pkg::KIND_COMP;
					end
					PH_KLEN, PH_VLEN: begin
						crc_d = crc_next;
						acc_d = acc_new;
						if (!b[7]) begin
							field_d = CW'(acc_new);
							acc_d = '0;
							shift_d = '0;
							phase_d = ph_done;
							if (ph_done == PH_CRC) begin
								field_d = '0;
								stored_d = '0;
							end
						end else if (shift_q >= 3'd4) begin
							if (tot1 >= kvd_pkg::MIN_RECORD) begin
								disc_d = 1'b1;
								res_valid = 1'b1;
								res.kind = kvd_pkg::KIND_STATUS;
								res.last = 1'b1;
								res.status_code = (phase_q == PH_KLEN) ? kvd_pkg::ST_KEY :
									kvd_pkg::ST_VAL;
							end else begin
								phase_d = (phase_q == PH_KLEN) ? PH_KEYBAD : PH_VALBAD;
							end
						end else begin
							shift_d = shift_q + 3'd1;
						end
					end
					PH_KEY, PH_VAL: begin
						crc_d = crc_next;
						field_d = fcd;
						if (fcd == '0) begin
							if (phase_q == PH_KEY) begin
								phase_d = PH_VLEN;
							end else begin
								phase_d = PH_CRC;
								stored_d = '0;
							end
						end
						res_valid = 1'b1;
						res.out_byte = b;
						res.kind = (phase_q == PH_KEY) ? kvd_pkg::KIND_KEY : kvd_pkg::KIND_VAL;
					end
					PH_CRC: begin
						stored_d = stored_new;
						field_d = fc1;
						if (fc1 >= CW'(4)) begin
							res_valid = 1'b1;
							res.kind = kvd_pkg::KIND_STATUS;
							res.last = 1'b1;
							if (kvd_pkg::crc_masked(crc_q) == stored_new) begin
								res.status_code = kvd_pkg::ST_OK;
								res.record_length = tot1;
								phase_d = PH_FP;
								field_d = '0;
								total_d = '0;
								acc_d = '0;
								shift_d = '0;
								crc_d = kvd_pkg::CRC_INIT;
								stored_d = '0;
								cfault_d = 1'b0;
							end else begin
								res.status_code = kvd_pkg::ST_CRC_BAD;
								disc_d = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FP;
			field_q <= '0;
			total_q <= '0;
			acc_q <= '0;
			shift_q <= '0;
			crc_q <= kvd_pkg::CRC_INIT;
			stored_q <= '0;
			cfault_q <= 1'b0;
			disc_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			field_q <= field_d;
			total_q <= total_d;
			acc_q <= acc_d;
			shift_q <= shift_d;
			crc_q <= crc_d;
			stored_q <= stored_d;
			cfault_q <= cfault_d;
			disc_q <= disc_d;
		end
	end

endmodule

`default_nettype wire

/* hdl/kv_record_deframer_crc32c_core.sv */
// Top level of the length-prefixed record deframer with CRC-32C check.
//
//   Port      Dir   Handshake      Beat contents
//   rec_in    in    valid/ready    mode, in_byte
//   rec_out   out   valid/ready    out_byte, kind, status_code, record_length, last
//   APB       in    psel/penable   raw_code at 0x0, lz4_code at 0x4
//
// One beat is accepted per cycle while rec_out is not stalled; a result passes first through
// the input register and then through the result register.
// The CRC-32C byte update and the field counters form the single step between them.
// arst_n clears the parser state, both valid flags and the codes to raw 0, lz4 1.
// While rec_out is stalled the result holds and the input register still fills once.
`default_nettype none

module kv_record_deframer_crc32c_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	kvd_in_if.sink           rec_in,
	kvd_out_if.source        rec_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	kvd_pkg::cfg_t  cfg;
	kvd_pkg::item_t item_s1;
	logic           valid_s1;
	logic           step;
	logic           res_valid;
	kvd_pkg::res_t  res;
	kvd_pkg::res_t  res_q;
	logic           out_valid_q;

	kvd_apb_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign step = valid_s1 && (!out_valid_q || rec_out.ready);
	assign rec_in.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rec_in.ready) begin
			valid_s1 <= rec_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_in.valid && rec_in.ready) begin
			item_s1.mode <= rec_in.mode;
			item_s1.in_byte <= rec_in.in_byte;
		end
	end

	kvd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.cfg      (cfg),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res_valid;
		end else if (rec_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign rec_out.valid = out_valid_q;
	assign rec_out.out_byte = res_q.out_byte;
	assign rec_out.kind = res_q.kind;
	assign rec_out.status_code = res_q.status_code;
	assign rec_out.record_length = res_q.record_length;
	assign rec_out.last = res_q.last;

endmodule

`default_nettype wire

/* hdl/kvd_checker.sv */
// Port-level checker for the deframer and the bind that attaches it.
`default_nettype none

module kvd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [7:0]                  out_byte,
	input wire logic [2:0]                  kind,
	input wire logic [2:0]                  status_code,
	input wire logic [kvd_pkg::CNT_W-1:0]   record_length,
	input wire logic                        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
			&& $stable(status_code) && $stable(record_length) && $stable(last))
		else $error("Result beat changed while stalled.");

	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind == kvd_pkg::KIND_STATUS)))
		else $error("The last flag does not match a status beat.");

	a_echo_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != kvd_pkg::KIND_STATUS |->
			status_code == kvd_pkg::ST_OK && record_length == '0)
		else $error("Echo beat carries status fields.");

	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && status_code != kvd_pkg::ST_OK |->
			record_length == '0 && out_byte == 8'd0)
		else $error("Error status carries a length or a byte.");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && status_code == kvd_pkg::ST_OK |->
			record_length >= kvd_pkg::MIN_RECORD)
		else $error("Good record is shorter than the minimum size.");

endmodule

bind kv_record_deframer_crc32c_core kvd_checker u_kvd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (rec_out.valid),
	.out_ready    (rec_out.ready),
	.out_byte     (rec_out.out_byte),
	.kind         (rec_out.kind),
	.status_code  (rec_out.status_code),
	.record_length(rec_out.record_length),
	.last         (rec_out.last)
);

`default_nettype wire

/* dv/kvd_record_checker.sv */
// Record checker: predicts deframer results from accepted input beats and compares them.
module kvd_record_checker
	import kvd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	kvd_in_if                rec_in,
	kvd_out_if               rec_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               mismatches,
	output int               pending,
	output int               results_seen,
	output int               good_records,
	output int               faulted_records
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		P_FP, P_COMP, P_KLEN, P_KEY, P_VLEN, P_VAL, P_CRC, P_KEYBAD, P_VALBAD
	} parse_phase_t;

	parse_phase_t     phase;
	logic [CNT_W-1:0] field_cnt;
	logic [CNT_W-1:0] rec_len;
	logic [31:0]      len_accum;
	logic [2:0]       len_bytes;
	logic [31:0]      crc_run;
	logic [31:0]      crc_stored;
	logic             comp_fault;
	logic             discarding;
	logic [7:0]       raw_code;
	logic [7:0]       lz4_code;
	res_t             expected_beats[$];

	function automatic logic [31:0] crc32c_step(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] x;
		x = c ^ {24'd0, d};
		repeat (8) x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		return x;
	endfunction

	task automatic start_record();
		phase = P_FP;
		field_cnt = '0;
		rec_len = '0;
		len_accum = '0;
		len_bytes = '0;
		crc_run = CRC_INIT;
		crc_stored = '0;
		comp_fault = 1'b0;
	endtask

	task automatic predict(input logic mode, input logic [7:0] b);
		res_t             r;
		logic             echo;
		logic             done;
		logic             is_key;
		logic [2:0]       code;
		logic [CNT_W-1:0] len;
		logic [63:0]      part;
		logic [31:0]      c;
		r = '0;
		echo = 1'b0;
		done = 1'b0;
		code = ST_TRUNC;
		len = '0;
		if (mode) begin
			if (discarding) begin
				discarding = 1'b0;
				start_record();
			end else if (rec_len != 0) begin
				if (rec_len < MIN_RECORD)
					code = ST_TRUNC;
				else if (comp_fault)
					code = ST_COMP;
				else if (phase == P_KLEN || phase == P_KEY || phase == P_KEYBAD)
					code = ST_KEY;
				else if (phase == P_VLEN || phase == P_VAL || phase == P_VALBAD)
					code = ST_VAL;
				else if (phase == P_CRC)
					code = ST_CRC_TRUNC;
				else
					code = ST_TRUNC;
				start_record();
				done = 1'b1;
			end
		end else if (!discarding) begin
			if (rec_len != COUNT_MAX)
				rec_len = rec_len + 1'b1;
			if (comp_fault || phase == P_KEYBAD || phase == P_VALBAD) begin
				if (rec_len >= MIN_RECORD) begin
					code = comp_fault ? ST_COMP : (phase == P_KEYBAD ? ST_KEY : ST_VAL);
					discarding = 1'b1;
					done = 1'b1;
				end
			end else begin
				case (phase)
					P_FP: begin
						crc_run = crc32c_step(crc_run, b);
						field_cnt = field_cnt + 1'b1;
						if (field_cnt >= FP_BYTES) begin
							field_cnt = '0;
							phase = P_COMP;
						end
						echo = 1'b1;
						r.kind = KIND_FP;
					end
					P_COMP: begin
						crc_run = crc32c_step(crc_run, b);
						if (b != raw_code && b != lz4_code)
							comp_fault = 1'b1;
						phase = P_KLEN;
						len_accum = '0;
						len_bytes = '0;
						echo = 1'b1;
						r.kind = KIND_COMP;
					end
					P_KLEN, P_VLEN: begin
						is_key = (phase == P_KLEN);
						crc_run = crc32c_step(crc_run, b);
						part = 64'(b[6:0]) << (7 * len_bytes);
						len_accum = len_accum | part[31:0];
						if (!b[7]) begin
							field_cnt = {1'b0, len_accum};
							len_accum = '0;
							len_bytes = '0;
							if (is_key)
								phase = (field_cnt != 0) ? P_KEY : P_VLEN;
							else
								phase = (field_cnt != 0) ? P_VAL : P_CRC;
							if (phase == P_CRC) begin
								field_cnt = '0;
								crc_stored = '0;
							end
						end else if (len_bytes >= 4) begin
							code = is_key ? ST_KEY : ST_VAL;
							if (rec_len >= MIN_RECORD) begin
								discarding = 1'b1;
								done = 1'b1;
							end else begin
								phase = is_key ? P_KEYBAD : P_VALBAD;
							end
						end else begin
							len_bytes = len_bytes + 1'b1;
						end
					end
					P_KEY, P_VAL: begin
						r.kind = (phase == P_KEY) ? KIND_KEY : KIND_VAL;
						crc_run = crc32c_step(crc_run, b);
						if (field_cnt != 0)
							field_cnt = field_cnt - 1'b1;
						if (field_cnt == 0) begin
							if (phase == P_KEY) begin
								phase = P_VLEN;
							end else begin
								phase = P_CRC;
								crc_stored = '0;
							end
						end
						echo = 1'b1;
					end
					P_CRC: begin
						crc_stored = crc_stored | (32'(b) << (8 * field_cnt[1:0]));
						field_cnt = field_cnt + 1'b1;
						if (field_cnt >= 4) begin
							c = ~crc_run;
							c = ((c >> 15) | (c << 17)) + CRC_MASK_DELTA;
							if (c == crc_stored) begin
								len = rec_len;
								code = ST_OK;
								start_record();
							end else begin
								code = ST_CRC_BAD;
								discarding = 1'b1;
							end
							done = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
		if (echo)
			r.out_byte = b;
		if (done) begin
			r.kind = KIND_STATUS;
			r.status_code = code;
			r.record_length = len;
			r.last = 1'b1;
		end
		if (echo || done)
			expected_beats.insert(expected_beats.size(), r);
	endtask

	task automatic check_result();
		res_t want;
		results_seen++;
		if (expected_beats.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%t: result beat with none expected: byte %02h kind %0d status %0d len %0d",
					$realtime, rec_out.out_byte, rec_out.kind, rec_out.status_code,
					rec_out.record_length);
		end else begin
			want = expected_beats.pop_front();
			if (rec_out.out_byte !== want.out_byte || rec_out.kind !== want.kind ||
					rec_out.status_code !== want.status_code ||
					rec_out.record_length !== want.record_length ||
					rec_out.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%t: result mismatch", $realtime);
					$display("  expected byte %02h kind %0d status %0d len %0d last %0d",
						want.out_byte, want.kind, want.status_code, want.record_length,
						want.last);
					$display("  actual   byte %02h kind %0d status %0d len %0d last %0d",
						rec_out.out_byte, rec_out.kind, rec_out.status_code,
						rec_out.record_length, rec_out.last);
				end
			end
			if (want.kind == KIND_STATUS) begin
				if (want.status_code == ST_OK)
					good_records++;
				else
					faulted_records++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_code = 8'h00;
			lz4_code = 8'h01;
			discarding = 1'b0;
			start_record();
			expected_beats.delete();
			mismatches = 0;
			pending = 0;
			results_seen = 0;
			good_records = 0;
			faulted_records = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_LZ4)
					lz4_code = pwdata[7:0];
				else
					raw_code = pwdata[7:0];
			end
			if (rec_in.valid && rec_in.ready)
				predict(rec_in.mode, rec_in.in_byte);
			if (rec_out.valid && rec_out.ready)
				check_result();
			pending = expected_beats.size();
		end
	end

endmodule

/* dv/kv_record_deframer_crc32c_core_test.sv */
// Top of the deframer testbench: clock, reset, record stimulus, register writes and verdict.
module kv_record_deframer_crc32c_core_test;
	import kvd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 600;

	typedef enum {FLAW_NONE, FLAW_CRC, FLAW_KEY_LEN, FLAW_VAL_LEN} flaw_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int pending;
	int results_seen;
	int good_records;
	int faulted_records;
	int cycles = 0;
	int items_sent = 0;
	bit quiet = 1'b0;
	bit wide_lengths = 1'b0;
	logic [7:0] raw_now = 8'h00;
	logic [7:0] lz4_now = 8'h01;
	logic [7:0] frame[$];

	kvd_in_if rec_in();
	kvd_out_if rec_out();

	kv_record_deframer_crc32c_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.rec_in(rec_in),
		.rec_out(rec_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	kvd_record_checker record_check (
		.clk(clk),
		.arst_n(arst_n),
		.rec_in(rec_in),
		.rec_out(rec_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.mismatches(mismatches),
		.pending(pending),
		.results_seen(results_seen),
		.good_records(good_records),
		.faulted_records(faulted_records)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("kv_record_deframer_crc32c_core_test: errors");
			$finish;
		end
	end

	function automatic logic [31:0] frame_crc();
		logic [31:0] c;
		c = CRC_INIT;
		foreach (frame[i]) begin
			c = c ^ {24'd0, frame[i]};
			for (int k = 0; k < 8; k++)
				c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		c = ~c;
		return ((c >> 15) | (c << 17)) + CRC_MASK_DELTA;
	endfunction

	function automatic int pick_length();
		if ($urandom_range(0, 39) == 0)
			return $urandom_range(100, 300);
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
	endfunction

	task automatic append_byte(input logic [7:0] v);
		frame.insert(frame.size(), v);
	endtask

	// Longer encodings than needed are legal; a fifth byte carries junk above bit 31.
	task automatic put_varint(input logic [31:0] v);
		int nb;
		logic [7:0] b;
		nb = 1;
		while (nb < 5 && (v >> (7 * nb)) != 0)
			nb++;
		if (wide_lengths)
			nb = 5;
		else if ($urandom_range(0, 3) == 0)
			nb = $urandom_range(nb, 5);
		for (int i = 0; i < nb; i++) begin
			b = {1'b0, v[6:0]};
			v = v >> 7;
			if (i == 4)
				b[6:4] = 3'($urandom_range(0, 7));
			if (i < nb - 1)
				b[7] = 1'b1;
			append_byte(b);
		end
	endtask

	task automatic build_record(input int klen, input int vlen, input logic [7:0] comp,
			input flaw_t flaw);
		logic [31:0] crc;
		frame.delete();
		repeat (FP_BYTES) append_byte(8'($urandom));
		append_byte(comp);
		if (flaw == FLAW_KEY_LEN) begin
			repeat (5) append_byte(8'($urandom) | 8'h80);
			repeat (klen) append_byte(8'($urandom));
			return;
		end
		put_varint(klen);
		repeat (klen) append_byte(8'($urandom));
		if (flaw == FLAW_VAL_LEN) begin
			repeat (5) append_byte(8'($urandom) | 8'h80);
			repeat (vlen) append_byte(8'($urandom));
			return;
		end
		put_varint(vlen);
		repeat (vlen) append_byte(8'($urandom));
		crc = frame_crc();
		if (flaw == FLAW_CRC)
			crc = crc ^ (32'd1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++)
			append_byte(crc[8*i +: 8]);
	endtask

	task automatic send_beat(input logic m, input logic [7:0] b, input bit counted);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			rec_in.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		rec_in.valid <= 1'b1;
		rec_in.mode <= m;
		rec_in.in_byte <= b;
		@(posedge clk);
		while (!rec_in.ready)
			@(posedge clk);
		@(negedge clk);
		if (counted)
			items_sent++;
	endtask

	task automatic send_frame(input int n);
		for (int i = 0; i < n; i++)
			send_beat(1'b0, frame[i], 1'b1);
	endtask

	task automatic send_end();
		send_beat(1'b1, 8'($urandom), 1'b1);
	endtask

	task automatic send_junk(input int n);
		repeat (n) send_beat(1'b0, 8'($urandom), 1'b0);
	endtask

	task automatic settle();
		rec_in.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_code(input logic idx, input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		if (idx == REG_LZ4)
			lz4_now = v;
		else
			raw_now = v;
	endtask

	task automatic random_record();
		int pick;
		int klen;
		int vlen;
		logic [7:0] comp;
		pick = $urandom_range(0, 99);
		klen = pick_length();
		vlen = pick_length();
		comp = $urandom_range(0, 1) ? raw_now : lz4_now;
		if (pick < 60) begin
			build_record(klen, vlen, comp, FLAW_NONE);
			send_frame(frame.size());
			if ($urandom_range(0, 3) == 0)
				send_end();
		end else if (pick < 70) begin
			build_record(klen, vlen, comp, FLAW_NONE);
			send_frame($urandom_range(1, frame.size() - 1));
			send_end();
		end else if (pick < 78) begin
			build_record(klen, vlen, comp, FLAW_CRC);
			send_frame(frame.size());
			send_junk($urandom_range(0, 6));
			send_end();
		end else if (pick < 86) begin
			do
				comp = 8'($urandom);
			while (comp == raw_now || comp == lz4_now);
			build_record(klen, vlen, comp, FLAW_NONE);
			send_frame($urandom_range(0, 1) ? frame.size() : $urandom_range(1, frame.size()));
			send_junk($urandom_range(0, 4));
			send_end();
		end else if (pick < 93) begin
			build_record(klen, vlen, comp,
				$urandom_range(0, 1) ? FLAW_KEY_LEN : FLAW_VAL_LEN);
			send_frame(frame.size());
			send_junk($urandom_range(0, 4));
			send_end();
		end else begin
			frame.delete();
			repeat ($urandom_range(1, 40)) append_byte(8'($urandom));
			send_frame(frame.size());
			send_end();
		end
	endtask

	initial begin
		int n;
		rec_out.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (quiet || $urandom_range(0, 2) != 0) begin
				rec_out.ready <= 1'b1;
				n = $urandom_range(1, 60);
			end else begin
				rec_out.ready <= 1'b0;
				n = $urandom_range(1, 18);
			end
			repeat (n) @(negedge clk);
		end
	end

	initial begin
		int base;
		arst_n = 1'b0;
		rec_in.valid = 1'b0;
		rec_in.mode = 1'b0;
		rec_in.in_byte = 8'h00;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed cases under the reset codes.
		send_end();
		build_record(0, 0, 8'h00, FLAW_NONE);
		send_frame(frame.size());
		wide_lengths = 1'b1;
		build_record(3, 5, 8'h01, FLAW_NONE);
		wide_lengths = 1'b0;
		send_frame(frame.size());
		send_end();
		build_record(4, 4, 8'h00, FLAW_NONE);
		send_frame(10);
		send_end();
		build_record(2, 2, 8'h7E, FLAW_NONE);
		send_frame(frame.size());
		send_junk(3);
		send_end();
		build_record(2, 2, 8'hFF, FLAW_NONE);
		send_frame(24);
		send_end();
		build_record(3, 0, 8'h00, FLAW_KEY_LEN);
		send_frame(frame.size());
		send_end();
		build_record(0, 0, 8'h01, FLAW_KEY_LEN);
		send_frame(frame.size());
		send_end();
		build_record(2, 0, 8'h00, FLAW_VAL_LEN);
		send_frame(frame.size());
		send_end();
		build_record(1, 1, 8'h00, FLAW_CRC);
		send_frame(frame.size());
		send_junk(4);
		send_end();
		build_record(1, 1, 8'h01, FLAW_NONE);
		send_frame(frame.size() - 2);
		send_end();
		build_record(10, 3, 8'h00, FLAW_NONE);
		send_frame(30);
		send_end();
		build_record(0, 12, 8'h00, FLAW_NONE);
		send_frame(30);
		send_end();
		build_record(5, 200, 8'h01, FLAW_NONE);
		send_frame(28);
		send_end();

		base = items_sent;
		for (int p = 0; p < 4; p++) begin
			settle();
			case (p)
				0: begin
					write_code(REG_RAW, 8'h00);
					write_code(REG_LZ4, 8'hFF);
				end
				1: begin
					write_code(REG_RAW, 8'hFF);
					write_code(REG_LZ4, 8'hFF);
				end
				2: begin
					write_code(REG_RAW, 8'($urandom));
					write_code(REG_LZ4, 8'($urandom));
				end
				default: begin
					write_code(REG_LZ4, 8'h7F);
					write_code(REG_RAW, 8'h80);
				end
			endcase
			while (items_sent < base + (RANDOM_ITEMS / 4) * (p + 1)) begin
				quiet = (items_sent >= base + RANDOM_ITEMS * 85 / 100);
				random_record();
				if (!quiet && $urandom_range(0, 11) == 0)
					settle();
			end
		end

		rec_in.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		$display("Sent %0d input beats and checked %0d result beats over %0d cycles.",
			items_sent, results_seen, cycles);
		$display("Records closed: %0d good, %0d with a fault status.",
			good_records, faulted_records);
		if (mismatches == 0)
			$display("kv_record_deframer_crc32c_core_test: clean");
		else
			$display("kv_record_deframer_crc32c_core_test: errors");
		$finish;
	end

endmodule
